// ===== design/dec_pkg.sv =====
// Shared types, codes and constants for the deduplicating event counter.
package dec_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned IdW = 256;
  localparam int unsigned TotalW = 7;

  localparam logic ReqLog = 1'b0;
  localparam logic ReqFinal = 1'b1;

  localparam logic [1:0] KindRouting = 2'd0;
  localparam logic [1:0] KindSensing = 2'd1;
  localparam logic [1:0] KindUptime = 2'd2;
  localparam logic [1:0] KindOther = 2'd3;

  localparam logic [1:0] ResReject = 2'd0;
  localparam logic [1:0] ResStore = 2'd1;
  localparam logic [1:0] ResFinal = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [63:0] id_word0;
    logic [63:0] id_word1;
    logic [63:0] id_word2;
    logic [63:0] id_word3;
    logic [1:0]  event_kind;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [TotalW-1:0] routing_total;
    logic [TotalW-1:0] sensing_total;
    logic [TotalW-1:0] uptime_total;
  } rsp_t;

  typedef struct packed {
    logic       accept;
    logic       read;
    logic       finish;
    logic [1:0] res;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic full;
    logic empty;
    logic more;
    logic hit;
    logic last_miss;
    logic out_free;
  } sts_t;

endpackage

// ===== design/dedup_event_counter.sv =====
// Top level of the deduplicating per-epoch event counter.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid_i / in_stall_o | dec_pkg::req_t in_data_i
//   out     | output    | out_valid_o / out_stall_i | dec_pkg::rsp_t out_data_o
//
// One request is in work at a time. A finalize or a request against a full or empty
// store is settled in the evaluation step; a log request otherwise is settled by a
// scan that reads one stored id per cycle from the single read port of the id
// memory, until it finds a match or reaches the last stored id.
// Reset clears the counters and the fill count; the id memory needs no clearing.
// A result waits in the output register under stall while the next request transfers.
module dedup_event_counter #(
  parameter int unsigned CAPACITY = dec_pkg::CapacityDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dec_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dec_pkg::rsp_t out_data_o
);

  dec_pkg::cmd_t cmd;
  dec_pkg::sts_t sts;

  dec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dec_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== design/dec_ctrl.sv =====
// Controller state machine that sequences request evaluation and the store scan.
module dec_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dec_pkg::sts_t sts_i,
  output dec_pkg::cmd_t cmd_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SEval = 2'd1;
  localparam logic [1:0] SScan = 2'd2;
  localparam logic [1:0] SWait = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] res_q, res_d;

  always_comb begin
    logic       fin_req;
    logic [1:0] fin_code;
    state_d  = state_q;
    res_d    = res_q;
    cmd_o    = '0;
    fin_req  = 1'b0;
    fin_code = dec_pkg::ResReject;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = SEval;
        end
      end
      SEval: begin
        if (sts_i.fin) begin
          fin_req  = 1'b1;
          fin_code = dec_pkg::ResFinal;
        end else if (sts_i.full) begin
          fin_req  = 1'b1;
          fin_code = dec_pkg::ResReject;
        end else if (sts_i.empty) begin
          fin_req  = 1'b1;
          fin_code = dec_pkg::ResStore;
        end else begin
          cmd_o.read = 1'b1;
          state_d    = SScan;
        end
      end
      SScan: begin
        if (sts_i.hit) begin
          fin_req  = 1'b1;
          fin_code = dec_pkg::ResReject;
        end else if (sts_i.last_miss) begin
          fin_req  = 1'b1;
          fin_code = dec_pkg::ResStore;
        end else if (sts_i.more) begin
          cmd_o.read = 1'b1;
        end
      end
      SWait: begin
        fin_req  = 1'b1;
        fin_code = res_q;
      end
      default: state_d = SIdle;
    endcase
    if (fin_req) begin
      if (sts_i.out_free) begin
        cmd_o.finish = 1'b1;
        cmd_o.res    = fin_code;
        state_d      = SIdle;
      end else begin
        res_d   = fin_code;
        state_d = SWait;
      end
    end
  end

  assign in_stall_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      res_q   <= dec_pkg::ResReject;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

// ===== design/dec_datapath.sv =====
// Datapath with the id memory, scan pipeline, counters and result register.
module dec_datapath #(
  parameter int unsigned CAPACITY = dec_pkg::CapacityDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dec_pkg::req_t in_data_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output dec_pkg::rsp_t out_data_o,
  input  dec_pkg::cmd_t cmd_i,
  output dec_pkg::sts_t sts_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  dec_pkg::req_t              req_q;
  logic [dec_pkg::IdW-1:0]    id;
  logic [dec_pkg::IdW-1:0]    mem_q [CAPACITY];
  logic [dec_pkg::IdW-1:0]    rd_data_q;
  logic                       rd_vld_q;
  logic                       rd_last_q;
  logic [CntW-1:0]            scan_q;
  logic [CntW-1:0]            count_q;
  logic [CntW-1:0]            routing_q;
  logic [CntW-1:0]            sensing_q;
  logic [CntW-1:0]            uptime_q;
  logic                       out_valid_q;
  dec_pkg::rsp_t              out_data_q;
  dec_pkg::rsp_t              rsp;
  logic                       hit;
  logic                       do_store;

  assign id       = {req_q.id_word0, req_q.id_word1, req_q.id_word2, req_q.id_word3};
  assign hit      = rd_vld_q && (rd_data_q == id);
  assign do_store = cmd_i.finish && (cmd_i.res == dec_pkg::ResStore);

  assign sts_o.fin       = (req_q.req_type == dec_pkg::ReqFinal);
  assign sts_o.full      = (count_q == CntW'(CAPACITY));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.more      = (scan_q < count_q);
  assign sts_o.hit       = hit;
  assign sts_o.last_miss = rd_vld_q && rd_last_q && !hit;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_store) begin
      mem_q[count_q[AddrW-1:0]] <= id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_data_q <= mem_q[scan_q[AddrW-1:0]];
      rd_last_q <= (scan_q == (count_q - CntW'(1)));
    end
  end

  always_comb begin
    rsp = '0;
    unique case (cmd_i.res)
      dec_pkg::ResStore: rsp.accepted = 1'b1;
      dec_pkg::ResFinal: begin
        rsp.accepted      = 1'b1;
        rsp.routing_total = dec_pkg::TotalW'(routing_q);
        rsp.sensing_total = dec_pkg::TotalW'(sensing_q);
        rsp.uptime_total  = dec_pkg::TotalW'(uptime_q);
      end
      default: rsp.accepted = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      scan_q      <= '0;
      count_q     <= '0;
      routing_q   <= '0;
      sensing_q   <= '0;
      uptime_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.read;
      if (cmd_i.accept) begin
        scan_q <= '0;
      end else if (cmd_i.read) begin
        scan_q <= scan_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish && (cmd_i.res == dec_pkg::ResFinal)) begin
        count_q   <= '0;
        routing_q <= '0;
        sensing_q <= '0;
        uptime_q  <= '0;
      end else if (do_store) begin
        count_q <= count_q + CntW'(1);
        case (req_q.event_kind)
          dec_pkg::KindRouting: routing_q <= routing_q + CntW'(1);
          dec_pkg::KindSensing: sensing_q <= sensing_q + CntW'(1);
          dec_pkg::KindUptime:  uptime_q  <= uptime_q + CntW'(1);
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/dec_checker.sv =====
// Port-level checker for the deduplicating event counter and its bind statement.
module dec_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input dec_pkg::rsp_t out_data_o
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // A request transfer always leaves the input busy, so no second request is taken back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken back to back");

  // A rejected log request reports zero totals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |->
      (out_data_o.routing_total == '0) && (out_data_o.sensing_total == '0) &&
      (out_data_o.uptime_total == '0))
    else $error("rejected result carries totals");

endmodule

bind dedup_event_counter dec_checker u_dec_checker (.*);
